// ===== sv/mtrl_pkg.sv =====
// Shared types and constants for the multibit trie route lookup block.
`timescale 1ns / 1ps
`default_nettype none
package mtrl_pkg;

  localparam int unsigned STRIDE_DEF = 4;
  localparam int unsigned NODES_DEF = 256;
  localparam int unsigned ADDR_BITS = 32;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int unsigned E_VALID_BIT = 31;
  localparam int unsigned E_CHILD_BIT = 30;

  // Controller states.
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LK_RD,
    S_LK_CHK,
    S_CT_RD,
    S_CT_CHK,
    S_IN_RD,
    S_IN_CHK,
    S_IN_FILL,
    S_IN_LINK,
    S_EX_RD,
    S_EX_CHK,
    S_SB_RD,
    S_SB_CHK,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd_walk;
    logic rd_exp;
    logic rd_sub;
    logic adv_node;
    logic need_inc;
    logic stop_follow;
    logic alloc_start;
    logic fill_wr;
    logic link_wr;
    logic exp_apply;
    logic exp_next;
    logic sub_start;
    logic sub_apply;
    logic reset_walk;
    logic set_res;
    logic [1:0] res_status;
    logic res_port;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic func;
    logic ent_valid;
    logic ent_child;
    logic ent_node_ok;
    logic more_strides;
    logic lk_more;
    logic follow;
    logic fits;
    logic fill_done;
    logic exp_last;
    logic sp_empty;
    logic sub_pos_ok;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/multibit_trie_route_lookup_core.sv =====
// Top level of the multibit trie route lookup block.
`timescale 1ns / 1ps
`default_nettype none
// Longest-prefix route table on a fixed-stride multibit trie with leaf pushing,
// held in one single-port slot memory of NODES << STRIDE words. After reset a
// clearing pass writes one slot a cycle until every slot is zero, before the
// first beat is taken. One beat is handled at a time, and the pace is set by
// the one memory read per stride. A lookup walks one stride per read. An insert
// takes a counting walk, then a build walk that fills and links each new node,
// then updates each covered slot and every subtree slot below it. A finished
// result waits for room in the output register before the next beat is taken.
module multibit_trie_route_lookup_core #(
  parameter int unsigned STRIDE = mtrl_pkg::STRIDE_DEF,
  parameter int unsigned NODES = mtrl_pkg::NODES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: address[31:0], prefix_len[37:32], next_hop[53:38], zero [55:54].
  input  wire logic [55:0] s_axis_tdata,
  // tuser: func.
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: port_out[15:0].
  output logic [15:0]      m_axis_tdata,
  // tuser: status[1:0].
  output logic [1:0]       m_axis_tuser
);

  mtrl_pkg::cmd_t  cmd;
  mtrl_pkg::stat_t st;
  logic            in_fire;
  logic [1:0]      rs;
  logic [15:0]     rp;
  logic            done_q;
  logic            out_free;
  logic            post;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign post = done_q && out_free;

  mtrl_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_fire_i(in_fire), .out_free_i(out_free),
    .st_i(st), .cmd_o(cmd), .in_ready_o(s_axis_tready)
  );

  mtrl_dp #(.STRIDE(STRIDE), .NODES(NODES)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd),
    .in_func_i(s_axis_tuser), .in_address_i(s_axis_tdata[31:0]),
    .in_prefix_len_i(s_axis_tdata[37:32]), .in_next_hop_i(s_axis_tdata[53:38]),
    .st_o(st), .res_status_o(rs), .res_port_o(rp)
  );

  // Output register: a result set by the controller is posted once the
  // previous beat has left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.set_res) done_q <= 1'b1;
      else if (post) done_q <= 1'b0;
      if (post) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (post) begin
      m_axis_tdata <= rp;
      m_axis_tuser <= rs;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mtrl_ctrl.sv =====
// Controller state machine for the multibit trie route lookup.
`timescale 1ns / 1ps
`default_nettype none
module mtrl_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_fire_i,
  input  wire logic           out_free_i,
  input  wire mtrl_pkg::stat_t st_i,
  output mtrl_pkg::cmd_t      cmd_o,
  output logic                in_ready_o
);

  mtrl_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtrl_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtrl_pkg::S_CLEAR: if (st_i.clr_done) state_d = mtrl_pkg::S_IDLE;
      mtrl_pkg::S_IDLE: begin
        if (in_fire_i) state_d = mtrl_pkg::S_LK_RD;
      end
      mtrl_pkg::S_LK_RD: begin
        if (st_i.func) begin
          state_d = st_i.more_strides ? mtrl_pkg::S_CT_CHK : mtrl_pkg::S_IN_RD;
        end else begin
          state_d = mtrl_pkg::S_LK_CHK;
        end
      end
      mtrl_pkg::S_LK_CHK: begin
        if (!st_i.ent_valid || !st_i.ent_child || !st_i.ent_node_ok || !st_i.lk_more) begin
          state_d = mtrl_pkg::S_DONE;
        end else begin
          state_d = mtrl_pkg::S_LK_CHK;
        end
      end
      mtrl_pkg::S_CT_RD: state_d = mtrl_pkg::S_CT_CHK;
      mtrl_pkg::S_CT_CHK: begin
        if (!st_i.more_strides) state_d = st_i.fits ? mtrl_pkg::S_IN_RD : mtrl_pkg::S_DONE;
        else state_d = mtrl_pkg::S_CT_CHK;
      end
      mtrl_pkg::S_IN_RD: state_d = st_i.more_strides ? mtrl_pkg::S_IN_CHK : mtrl_pkg::S_EX_RD;
      mtrl_pkg::S_IN_CHK: begin
        if (st_i.ent_valid && st_i.ent_child && st_i.ent_node_ok) state_d = mtrl_pkg::S_IN_RD;
        else state_d = mtrl_pkg::S_IN_FILL;
      end
      mtrl_pkg::S_IN_FILL: if (st_i.fill_done) state_d = mtrl_pkg::S_IN_LINK;
      mtrl_pkg::S_IN_LINK: state_d = mtrl_pkg::S_IN_RD;
      mtrl_pkg::S_EX_RD: state_d = mtrl_pkg::S_EX_CHK;
      mtrl_pkg::S_EX_CHK: begin
        if (st_i.ent_valid && st_i.ent_child) state_d = mtrl_pkg::S_SB_RD;
        else if (st_i.exp_last) state_d = mtrl_pkg::S_DONE;
        else state_d = mtrl_pkg::S_EX_RD;
      end
      mtrl_pkg::S_SB_RD: begin
        if (st_i.sp_empty) state_d = st_i.exp_last ? mtrl_pkg::S_DONE : mtrl_pkg::S_EX_RD;
        else if (st_i.sub_pos_ok) state_d = mtrl_pkg::S_SB_CHK;
        else state_d = mtrl_pkg::S_SB_RD;
      end
      mtrl_pkg::S_SB_CHK: state_d = mtrl_pkg::S_SB_RD;
      mtrl_pkg::S_DONE: if (out_free_i) state_d = mtrl_pkg::S_IDLE;
      default: state_d = mtrl_pkg::S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mtrl_pkg::S_CLEAR: cmd_o.clr_wr = 1'b1;
      mtrl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_fire_i;
      end
      mtrl_pkg::S_LK_RD: begin
        cmd_o.rd_walk = 1'b1;
      end
      mtrl_pkg::S_LK_CHK: begin
        if (!st_i.ent_valid || (st_i.ent_child && !st_i.ent_node_ok) ||
            (st_i.ent_child && !st_i.lk_more)) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = mtrl_pkg::ST_MISS;
        end else if (!st_i.ent_child) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = mtrl_pkg::ST_OK;
          cmd_o.res_port = 1'b1;
        end else begin
          cmd_o.adv_node = 1'b1;
          cmd_o.rd_walk = 1'b1;
        end
      end
      mtrl_pkg::S_CT_RD: cmd_o.rd_walk = 1'b1;
      mtrl_pkg::S_CT_CHK: begin
        if (!st_i.more_strides) begin
          cmd_o.reset_walk = 1'b1;
          if (!st_i.fits) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_status = mtrl_pkg::ST_FULL;
          end
        end else if (st_i.follow && st_i.ent_valid && st_i.ent_child && st_i.ent_node_ok) begin
          cmd_o.adv_node = 1'b1;
          cmd_o.rd_walk = 1'b1;
        end else begin
          cmd_o.need_inc = 1'b1;
          cmd_o.stop_follow = 1'b1;
          cmd_o.rd_walk = 1'b1;
        end
      end
      mtrl_pkg::S_IN_RD: begin
        if (st_i.more_strides) cmd_o.rd_walk = 1'b1;
      end
      mtrl_pkg::S_IN_CHK: begin
        if (st_i.ent_valid && st_i.ent_child && st_i.ent_node_ok) cmd_o.adv_node = 1'b1;
        else cmd_o.alloc_start = 1'b1;
      end
      mtrl_pkg::S_IN_FILL: cmd_o.fill_wr = 1'b1;
      mtrl_pkg::S_IN_LINK: cmd_o.link_wr = 1'b1;
      mtrl_pkg::S_EX_RD: cmd_o.rd_exp = 1'b1;
      mtrl_pkg::S_EX_CHK: begin
        cmd_o.exp_apply = 1'b1;
        if (st_i.ent_valid && st_i.ent_child) begin
          cmd_o.sub_start = 1'b1;
        end else if (st_i.exp_last) begin
          cmd_o.set_res = 1'b1;
          cmd_o.res_status = mtrl_pkg::ST_OK;
        end else begin
          cmd_o.exp_next = 1'b1;
        end
      end
      mtrl_pkg::S_SB_RD: begin
        if (st_i.sp_empty) begin
          if (st_i.exp_last) begin
            cmd_o.set_res = 1'b1;
            cmd_o.res_status = mtrl_pkg::ST_OK;
          end else begin
            cmd_o.exp_next = 1'b1;
          end
        end else begin
          cmd_o.rd_sub = 1'b1;
        end
      end
      mtrl_pkg::S_SB_CHK: cmd_o.sub_apply = 1'b1;
      mtrl_pkg::S_DONE: ;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // The input side is only open in the idle state.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == mtrl_pkg::S_IDLE) else $error("ready outside idle");
  // An accepted beat always starts a walk.
  a_fire_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |=> state_q == mtrl_pkg::S_LK_RD) else $error("beat not started");
  // A result that is set is always followed by the done state.
  a_res_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_res |=> state_q == mtrl_pkg::S_DONE) else $error("result not finished");
`endif

endmodule
`default_nettype wire

// ===== sv/mtrl_dp.sv =====
// Datapath for the multibit trie: slot memory, walk registers and subtree stack.
`timescale 1ns / 1ps
`default_nettype none
module mtrl_dp #(
  parameter int unsigned STRIDE = mtrl_pkg::STRIDE_DEF,
  parameter int unsigned NODES = mtrl_pkg::NODES_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mtrl_pkg::cmd_t  cmd_i,
  input  wire logic            in_func_i,
  input  wire logic [31:0]     in_address_i,
  input  wire logic [5:0]      in_prefix_len_i,
  input  wire logic [15:0]     in_next_hop_i,
  output mtrl_pkg::stat_t      st_o,
  output logic [1:0]           res_status_o,
  output logic [15:0]          res_port_o
);

  localparam int unsigned SLOTS = 1 << STRIDE;
  localparam int unsigned NB = $clog2(NODES);
  localparam int unsigned AW = NB + STRIDE;
  localparam int unsigned TS = NODES * SLOTS;
  localparam int unsigned DEPTH = mtrl_pkg::ADDR_BITS / STRIDE + 2;
  localparam int unsigned SPW = $clog2(DEPTH + 1);
  localparam int unsigned CW = 7;
  localparam int unsigned NCW = NB + 1;

  logic [31:0] mem [TS];
  logic [31:0] rd_q;
  logic        func_q;
  logic [31:0] addr_q;
  logic [5:0]  len_q;
  logic [15:0] hop_q;
  logic [NB-1:0] node_q;
  logic [CW-1:0] cons_q;
  logic          follow_q;
  logic [NCW-1:0] need_q;
  logic [NCW-1:0] free_q;
  logic [AW-1:0]  pos_q;
  logic [NB-1:0]  fresh_q;
  logic [31:0]    fillv_q;
  logic [STRIDE-1:0] fcnt_q;
  logic [STRIDE:0]   ek_q;
  logic [AW:0]    clr_q;
  logic [AW-1:0]  stk_q [DEPTH];
  logic [SPW-1:0] sp_q;
  logic [AW-1:0]  spos_q;
  logic [1:0]     rs_q;
  logic [15:0]    rp_q;

  // Address chunk for the current depth; bits past the address read zero.
  logic [31+STRIDE:0] ext;
  logic [STRIDE-1:0]  chunk;
  logic [CW-1:0]      left;
  logic [STRIDE:0]    span;
  logic [STRIDE-1:0]  ebase, eslot;
  logic [AW-1:0]      top, wpos;
  logic [31:0]        leaf;
  logic               wr_en;
  logic [AW-1:0]      wr_a;
  logic [31:0]        wr_d;
  logic [AW-1:0]      rd_a;
  logic               rd_en;
  logic               leaf_wins;

  assign ext = {addr_q, {STRIDE{1'b0}}} >> (mtrl_pkg::ADDR_BITS - 32'(cons_q));
  assign chunk = ext[STRIDE-1:0];
  assign left = CW'(len_q) - cons_q;
  assign span = (STRIDE+1)'(1) << (STRIDE - int'(left));
  assign ebase = chunk & ~STRIDE'(span - 1'b1);
  assign eslot = ebase + ek_q[STRIDE-1:0];
  assign wpos = {node_q, chunk};
  assign top = stk_q[sp_q - 1'b1];
  assign leaf = {1'b1, 9'd0, len_q, hop_q};
  assign leaf_wins = !rd_q[mtrl_pkg::E_VALID_BIT] ||
                     (!rd_q[mtrl_pkg::E_CHILD_BIT] && len_q >= rd_q[21:16]);

  // Chunk of the next stride, used when the walk advances in the same cycle.
  function automatic logic [STRIDE-1:0] ext_next(input mtrl_pkg::cmd_t c);
    logic [31+STRIDE:0] e;
    e = {addr_q, {STRIDE{1'b0}}} >> (mtrl_pkg::ADDR_BITS - 32'(cons_q) - STRIDE);
    ext_next = c.adv_node ? e[STRIDE-1:0] : chunk;
  endfunction

  // Status toward the controller.
  always_comb begin
    st_o.clr_done = clr_q == (AW+1)'(TS - 1);
    st_o.func = func_q;
    st_o.ent_valid = rd_q[mtrl_pkg::E_VALID_BIT];
    st_o.ent_child = rd_q[mtrl_pkg::E_CHILD_BIT];
    st_o.ent_node_ok = 32'(rd_q[11:0]) < NODES;
    st_o.more_strides = 32'(cons_q) + STRIDE < 32'(len_q);
    st_o.lk_more = 32'(cons_q) + STRIDE < mtrl_pkg::ADDR_BITS;
    st_o.follow = follow_q;
    st_o.fits = (32'(free_q) <= NODES) && (32'(need_q) <= NODES - 32'(free_q));
    st_o.fill_done = fcnt_q == STRIDE'(SLOTS - 1);
    st_o.exp_last = 32'(ek_q) + 1 >= 32'(span);
    st_o.sp_empty = sp_q == '0;
    st_o.sub_pos_ok = 1'b1;
  end

  // Memory port selection.
  always_comb begin
    wr_en = 1'b0; wr_a = pos_q; wr_d = leaf;
    rd_en = 1'b0; rd_a = wpos;
    if (cmd_i.clr_wr) begin
      wr_en = 1'b1; wr_a = clr_q[AW-1:0]; wr_d = '0;
    end else if (cmd_i.fill_wr) begin
      wr_en = 1'b1; wr_a = {fresh_q, fcnt_q}; wr_d = fillv_q;
    end else if (cmd_i.link_wr) begin
      wr_en = 1'b1; wr_a = pos_q;
      wr_d = {2'b11, 18'd0, 12'(fresh_q)};
    end else if ((cmd_i.exp_apply || cmd_i.sub_apply) && leaf_wins) begin
      wr_en = 1'b1; wr_a = pos_q; wr_d = leaf;
    end
    if (cmd_i.rd_walk) begin
      rd_en = 1'b1;
      rd_a = cmd_i.adv_node ? {rd_q[NB-1:0], ext_next(cmd_i)} : wpos;
    end else if (cmd_i.rd_exp) begin
      rd_en = 1'b1; rd_a = {node_q, eslot};
    end else if (cmd_i.rd_sub) begin
      rd_en = 1'b1; rd_a = top;
    end
  end

  // Slot memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_a] <= wr_d;
    if (rd_en) rd_q <= mem[rd_a];
  end

  // Walk and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      free_q <= NCW'(1);
      sp_q <= '0;
      rs_q <= '0;
      rp_q <= '0;
      func_q <= 1'b0;
      node_q <= '0;
      cons_q <= '0;
      follow_q <= 1'b1;
      need_q <= '0;
      fcnt_q <= '0;
      ek_q <= '0;
    end else begin
      if (cmd_i.clr_wr && !st_o.clr_done) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) begin
        func_q <= in_func_i;
        node_q <= '0;
        cons_q <= '0;
        follow_q <= 1'b1;
        need_q <= '0;
        ek_q <= '0;
        sp_q <= '0;
      end
      if (cmd_i.adv_node) begin
        node_q <= rd_q[NB-1:0];
        cons_q <= cons_q + CW'(STRIDE);
      end
      if (cmd_i.need_inc) begin
        need_q <= need_q + 1'b1;
        follow_q <= 1'b0;
        cons_q <= cons_q + CW'(STRIDE);
      end
      if (cmd_i.reset_walk) begin
        node_q <= '0;
        cons_q <= '0;
      end
      if (cmd_i.alloc_start) begin
        fresh_q <= free_q[NB-1:0];
        free_q <= free_q + 1'b1;
        pos_q <= wpos;
        fillv_q <= rd_q[mtrl_pkg::E_VALID_BIT] ? rd_q : '0;
        fcnt_q <= '0;
      end
      if (cmd_i.fill_wr) fcnt_q <= fcnt_q + 1'b1;
      if (cmd_i.link_wr) begin
        node_q <= fresh_q;
        cons_q <= cons_q + CW'(STRIDE);
      end
      if (cmd_i.rd_exp) pos_q <= {node_q, eslot};
      if (cmd_i.exp_next) ek_q <= ek_q + 1'b1;
      if (cmd_i.sub_start) begin
        stk_q[0] <= {rd_q[NB-1:0], {STRIDE{1'b0}}};
        sp_q <= SPW'(1);
      end
      if (cmd_i.rd_sub) begin
        pos_q <= top;
        if (top[STRIDE-1:0] == {STRIDE{1'b1}}) sp_q <= sp_q - 1'b1;
        else stk_q[sp_q - 1'b1] <= top + 1'b1;
      end
      if (cmd_i.sub_apply && rd_q[mtrl_pkg::E_VALID_BIT] && rd_q[mtrl_pkg::E_CHILD_BIT] &&
          32'(rd_q[11:0]) < NODES && 32'(sp_q) < DEPTH) begin
        stk_q[sp_q[SPW-1:0]] <= {rd_q[NB-1:0], {STRIDE{1'b0}}};
        sp_q <= sp_q + 1'b1;
      end
      if (cmd_i.set_res) begin
        rs_q <= cmd_i.res_status;
        rp_q <= cmd_i.res_port ? rd_q[15:0] : 16'd0;
      end
    end
  end

  // The beat's operands are held for the whole walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= in_address_i;
      len_q <= (in_prefix_len_i > 6'd32) ? 6'd32 : in_prefix_len_i;
      hop_q <= in_next_hop_i;
    end
  end

  assign res_status_o = rs_q;
  assign res_port_o = rp_q;

`ifndef SYNTHESIS
  // The stack never grows past its depth.
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= DEPTH) else $error("walk stack overflow");
  // The node counter never passes the node count.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_q) <= NODES) else $error("node counter overflow");
  // A freshly allocated node always lies within the node count.
  a_fill_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_start |=> 32'(fresh_q) < NODES) else $error("bad fresh node");
`endif

endmodule
`default_nettype wire

// ===== bench/multibit_trie_route_lookup_core_tb.sv =====
// Self-checking testbench for the multibit trie route lookup core.
`timescale 1ns / 1ps
module multibit_trie_route_lookup_core_tb;

  localparam int unsigned STRIDE = mtrl_pkg::STRIDE_DEF;
  localparam int unsigned NODES = mtrl_pkg::NODES_DEF;
  localparam int unsigned SLOTS = 1 << STRIDE;
  localparam int unsigned TBL = NODES << STRIDE;
  localparam int unsigned DEPTH = mtrl_pkg::ADDR_BITS / STRIDE + 2;
  localparam logic FN_LOOKUP = 1'b0;
  localparam logic FN_INSERT = 1'b1;
  localparam int unsigned N_RANDOM = 1430;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  multibit_trie_route_lookup_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] port;
  } route_res_t;

  // Shadow copy of the route trie.
  logic [31:0] shadow_slot [TBL];
  int unsigned shadow_free;
  int unsigned trie_stack [DEPTH];
  route_res_t  pending_q [$];
  int unsigned errors = 0;
  int unsigned n_results = 0;
  int unsigned n_inserts = 0;
  int unsigned n_hits = 0;
  int unsigned n_full = 0;
  bit          quiet = 1'b0;
  logic [31:0] known_prefix [$];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned nibble(logic [31:0] addr, int unsigned used);
    logic [63:0] v;
    v = {32'd0, addr} << STRIDE;
    return 32'((v >> (mtrl_pkg::ADDR_BITS - used)) & (SLOTS - 1));
  endfunction

  function automatic logic [31:0] leaf_word(int unsigned len, logic [15:0] port);
    return {1'b1, 1'b0, 8'd0, 6'(len), port};
  endfunction

  // Writes the route into an empty or leaf slot unless a longer one is there; returns the child or -1.
  function automatic int merge_slot(int unsigned pos, int unsigned len, logic [15:0] port);
    logic [31:0] e;
    e = shadow_slot[pos];
    if (!e[mtrl_pkg::E_VALID_BIT]) begin
      shadow_slot[pos] = leaf_word(len, port);
    end else if (!e[mtrl_pkg::E_CHILD_BIT]) begin
      if (len >= e[21:16]) shadow_slot[pos] = leaf_word(len, port);
    end else begin
      return int'(e[11:0]);
    end
    return -1;
  endfunction

  // Pushes the route into every leaf of the subtree below a node.
  function automatic void push_subtree(int unsigned node, int unsigned len, logic [15:0] port);
    int unsigned sp;
    int unsigned pos;
    int ch;
    if (node >= NODES) return;
    sp = 0;
    trie_stack[sp++] = node << STRIDE;
    while (sp > 0) begin
      pos = trie_stack[sp - 1];
      if ((pos & (SLOTS - 1)) == SLOTS - 1) sp--;
      else trie_stack[sp - 1] = pos + 1;
      if (pos >= TBL) continue;
      ch = merge_slot(pos, len, port);
      if (ch >= 0 && ch < NODES && sp < DEPTH) trie_stack[sp++] = ch << STRIDE;
    end
  endfunction

  function automatic route_res_t insert_route(logic [31:0] addr, int unsigned len,
                                              logic [15:0] port);
    int unsigned node, used, need, pos, fresh, left, span, base;
    logic [31:0] e, fill;
    bit follow;
    int ch;
    node = 0; used = 0; need = 0; follow = 1;
    while (used + STRIDE < len) begin
      if (follow) begin
        e = shadow_slot[(node << STRIDE) | nibble(addr, used)];
        if (e[mtrl_pkg::E_VALID_BIT] && e[mtrl_pkg::E_CHILD_BIT] && e[11:0] < NODES)
          node = e[11:0];
        else begin
          follow = 0;
          need++;
        end
      end else need++;
      used += STRIDE;
    end
    if (shadow_free > NODES || need > NODES - shadow_free)
      return '{mtrl_pkg::ST_FULL, 16'd0};
    node = 0; used = 0;
    while (used + STRIDE < len) begin
      pos = (node << STRIDE) | nibble(addr, used);
      e = shadow_slot[pos];
      if (e[mtrl_pkg::E_VALID_BIT] && e[mtrl_pkg::E_CHILD_BIT] && e[11:0] < NODES)
        node = e[11:0];
      else begin
        fresh = shadow_free++;
        fill = e[mtrl_pkg::E_VALID_BIT] ? e : 32'd0;
        for (int s = 0; s < SLOTS; s++) shadow_slot[(fresh << STRIDE) | s] = fill;
        shadow_slot[pos] = {2'b11, 30'(fresh)};
        node = fresh;
      end
      used += STRIDE;
    end
    left = len - used;
    span = 1 << (STRIDE - left);
    base = nibble(addr, used) & ~(span - 1) & (SLOTS - 1);
    for (int k = 0; k < span; k++) begin
      ch = merge_slot((node << STRIDE) | ((base + k) & (SLOTS - 1)), len, port);
      if (ch >= 0) push_subtree(ch, len, port);
    end
    return '{mtrl_pkg::ST_OK, 16'd0};
  endfunction

  function automatic route_res_t lookup_route(logic [31:0] addr);
    int unsigned node, used;
    logic [31:0] e;
    node = 0; used = 0;
    while (used < mtrl_pkg::ADDR_BITS) begin
      e = shadow_slot[(node << STRIDE) | nibble(addr, used)];
      if (!e[mtrl_pkg::E_VALID_BIT]) return '{mtrl_pkg::ST_MISS, 16'd0};
      if (!e[mtrl_pkg::E_CHILD_BIT]) return '{mtrl_pkg::ST_OK, e[15:0]};
      node = e[11:0];
      if (node >= NODES) return '{mtrl_pkg::ST_MISS, 16'd0};
      used += STRIDE;
    end
    return '{mtrl_pkg::ST_MISS, 16'd0};
  endfunction

  function automatic route_res_t predict_route(logic fn, logic [31:0] addr,
                                               logic [5:0] plen, logic [15:0] hop);
    int unsigned len;
    len = (plen > mtrl_pkg::ADDR_BITS) ? mtrl_pkg::ADDR_BITS : plen;
    if (fn == FN_INSERT) return insert_route(addr, len, hop);
    return lookup_route(addr);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("ERROR %0t: %s got %0d expected %0d (result %0d)", $realtime, what, got, want,
             n_results);
  endtask

  // Sends one beat and queues its expected result; a typed result is checked too.
  task automatic send_beat(logic fn, logic [31:0] addr, logic [5:0] plen,
                           logic [15:0] hop, bit typed, route_res_t want);
    route_res_t pred;
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {2'b00, hop, plen, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_route(fn, addr, plen, hop);
    if (typed && pred != want) report_mismatch("typed row vs predictor", pred, want);
    if (fn == FN_INSERT) begin
      n_inserts++;
      known_prefix.push_back(addr);
      if (known_prefix.size() > 64) void'(known_prefix.pop_front());
    end
    pending_q.push_back(pred);
  endtask

  // Result side: random stalls and the in-order compare.
  initial begin
    route_res_t want;
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected result beat, status", m_axis_tuser, 0);
        end else begin
          want = pending_q.pop_front();
          if (m_axis_tuser != want.status) report_mismatch("status", m_axis_tuser, want.status);
          if (m_axis_tdata != want.port) report_mismatch("port_out", m_axis_tdata, want.port);
          if (want.status == mtrl_pkg::ST_OK && want.port != 0) n_hits++;
          if (want.status == mtrl_pkg::ST_FULL) n_full++;
        end
      end
    end
  end

  // Directed rows: func, address, prefix_len, next_hop, typed, expected.
  typedef struct {
    logic        fn;
    logic [31:0] addr;
    logic [5:0]  plen;
    logic [15:0] hop;
    bit          typed;
    route_res_t  want;
  } route_row_t;

  route_row_t dir_rows [] = '{
    '{FN_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1, '{mtrl_pkg::ST_MISS, 16'd0}},
    '{FN_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1, '{mtrl_pkg::ST_MISS, 16'd0}},
    '{FN_INSERT, 32'h0A00_0000, 6'd8,  16'h0001, 1, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'h0A01_0203, 6'd0,  16'h0000, 1, '{mtrl_pkg::ST_OK, 16'h0001}},
    '{FN_INSERT, 32'h0A0B_0000, 6'd16, 16'h0002, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'h0A0B_FFFF, 6'd0,  16'h0000, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'h0A0C_0000, 6'd0,  16'h0000, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_INSERT, 32'h0000_0000, 6'd0,  16'h00FF, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'hC0A8_0001, 6'd0,  16'h0000, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'hFFFF_FFFF, 6'd0,  16'h0000, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'hFFFF_FFFE, 6'd0,  16'h0000, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_INSERT, 32'hAAAA_AAAA, 6'd63, 16'h5555, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'hAAAA_AAAA, 6'd0,  16'h0000, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_INSERT, 32'h0A0B_FFFF, 6'd9,  16'h0003, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_INSERT, 32'h0A00_0000, 6'd8,  16'h0004, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'h0A80_0000, 6'd0,  16'h0000, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'h0A0B_1234, 6'd0,  16'h0000, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_INSERT, 32'h1234_5678, 6'd3,  16'h0007, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_INSERT, 32'h5555_5555, 6'd1,  16'h8000, 0, '{mtrl_pkg::ST_OK, 16'd0}},
    '{FN_LOOKUP, 32'h5555_5555, 6'd0,  16'h0000, 0, '{mtrl_pkg::ST_OK, 16'd0}}
  };

  // Random prefix length, mostly short so the node store fills slowly.
  function automatic logic [5:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 6'($urandom_range(1, 12));
    if (r < 80) return 6'($urandom_range(13, 24));
    if (r < 95) return 6'($urandom_range(25, 32));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned count, bit build_heavy);
    logic [31:0] addr;
    logic [31:0] mask;
    logic        fn;
    for (int unsigned i = 0; i < count; i++) begin
      fn = ($urandom_range(0, 99) < (build_heavy ? 60 : 35)) ? FN_INSERT : FN_LOOKUP;
      addr = $urandom();
      // Lookups mostly land near prefixes already present.
      if (fn == FN_LOOKUP && known_prefix.size() != 0 && $urandom_range(0, 3) != 0) begin
        mask = 32'hFFFF_FFFF << $urandom_range(0, 28);
        addr = (known_prefix[$urandom_range(0, known_prefix.size() - 1)] & mask)
               | ($urandom() & ~mask);
      end
      send_beat(fn, addr, pick_len(), 16'($urandom()), 0, '{mtrl_pkg::ST_OK, 16'd0});
    end
  endtask

  initial begin
    foreach (shadow_slot[i]) shadow_slot[i] = 32'd0;
    shadow_free = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].fn, dir_rows[i].addr, dir_rows[i].plen, dir_rows[i].hop,
                dir_rows[i].typed, dir_rows[i].want);
    s_axis_tvalid <= 1'b0;
    // Hold off until the block has answered everything so far.
    drain();
    random_phase(N_RANDOM * 6 / 10, 1);
    s_axis_tvalid <= 1'b0;
    drain();
    // Fill the node store with long random prefixes to reach the full case.
    for (int unsigned i = 0; i < 120; i++)
      send_beat(FN_INSERT, $urandom(), 6'd32, 16'($urandom()), 0,
                '{mtrl_pkg::ST_OK, 16'd0});
    quiet = 1'b1;
    random_phase(N_RANDOM * 4 / 10 - 120, 0);
    s_axis_tvalid <= 1'b0;
    drain();
    $display("Covered %0d results, %0d inserts, %0d hits with a nonzero port,", n_results,
             n_inserts, n_hits);
    $display("and %0d inserts dropped for a full store; %0d nodes in use.", n_full,
             shadow_free);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Timeout guard: clearing pass plus a budget that covers a full subtree walk per item.
  initial begin
    #(12 * 40_000_000);
    $display("TIMEOUT, %0d results still expected", pending_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
